/* sv/assert_macros.svh */
// Assertion helpers; the enclosing module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PSV_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PSV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/psv_pkg.sv */
`default_nettype none
package psv_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } psv_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] matched_length;
    logic        big_endian;
    logic        nanosecond;
    logic [31:0] version;
    logic [24:0] snap_length;
    logic [31:0] link_type;
    logic [31:0] packet_count;
    logic [31:0] first_seconds;
    logic [31:0] first_fraction;
    logic [31:0] final_seconds;
    logic [31:0] final_fraction;
  } psv_out_t;

  typedef enum logic [1:0] {
    PH_GLOBAL,
    PH_RECORD,
    PH_PAYLOAD
  } psv_phase_t;

  localparam logic [2:0] ST_NO_MATCH       = 3'd0;
  localparam logic [2:0] ST_MATCHED        = 3'd1;
  localparam logic [2:0] ST_PARTIAL_GLOBAL = 3'd2;
  localparam logic [2:0] ST_PARTIAL_RECORD = 3'd3;
  localparam logic [2:0] ST_PARTIAL_DATA   = 3'd4;

  localparam logic [31:0] MAGIC_USEC = 32'hA1B2_C3D4;
  localparam logic [31:0] MAGIC_NSEC = 32'hA1B2_3C4D;
  localparam logic [31:0] SNAP_MAX   = 32'h0100_0000;

  localparam logic [4:0] GLOBAL_LAST = 5'd23;
  localparam logic [3:0] RECORD_LAST = 4'd15;

  // Global header word slots
  localparam logic [2:0] GW_MAGIC   = 3'd0;
  localparam logic [2:0] GW_VERSION = 3'd1;
  localparam logic [2:0] GW_SNAP    = 3'd4;
  localparam logic [2:0] GW_LINK    = 3'd5;

  // Record header word slots
  localparam logic [1:0] RW_SECONDS  = 2'd0;
  localparam logic [1:0] RW_FRACTION = 2'd1;
  localparam logic [1:0] RW_INCL     = 2'd2;

endpackage
`default_nettype wire

/* sv/psv_core.sv */
`default_nettype none
module psv_core import psv_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     adv,
  input  wire psv_in_t  step,
  output logic          res_valid,
  output psv_out_t      res
);

  localparam int WB = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt, rstart_r, rstart_nxt;
  psv_phase_t             phase_r, phase_nxt;
  logic [23:0]            shift_r;
  logic [3:0]             hpos_r, hpos_nxt;
  logic                   bad_r, bad_nxt, be_r, be_nxt, ns_r, ns_nxt, done_r;
  logic [31:0]            ver_r, ver_nxt, link_r, link_nxt;
  logic [24:0]            snap_r, snap_nxt, pl_r, pl_nxt;
  logic [31:0]            rw0_r, rw0_nxt, rw1_r, rw1_nxt, rw2_r, rw2_nxt;
  logic [31:0]            pkts_r, pkts_nxt;
  logic [31:0]            fsec_r, fsec_nxt, ffrac_r, ffrac_nxt;
  logic [31:0]            lsec_r, lsec_nxt, lfrac_r, lfrac_nxt;

  logic [31:0]            w, swp, hw;
  logic [24:0]            pl_dec;
  logic                   verdict, vdet, finish, clr;
  logic [2:0]             vstat;
  logic [LENGTH_BITS-1:0] vlen, len_sel;
  logic [WB-1:0]          len_ext;
  logic                   det;

  assign w   = {shift_r, step.byte_value};
  assign swp = {w[7:0], w[15:8], w[23:16], w[31:24]};
  assign hw  = be_r ? w : swp;
  assign clr = adv && step.last_byte;

  always_comb begin
    cnt_nxt    = (cnt_r != '1) ? cnt_r + 1'b1 : cnt_r;
    phase_nxt  = phase_r;
    hpos_nxt   = hpos_r;
    bad_nxt    = bad_r;
    be_nxt     = be_r;
    ns_nxt     = ns_r;
    ver_nxt    = ver_r;
    snap_nxt   = snap_r;
    link_nxt   = link_r;
    rw0_nxt    = rw0_r;
    rw1_nxt    = rw1_r;
    rw2_nxt    = rw2_r;
    pl_nxt     = pl_r;
    rstart_nxt = rstart_r;
    pkts_nxt   = pkts_r;
    fsec_nxt   = fsec_r;
    ffrac_nxt  = ffrac_r;
    lsec_nxt   = lsec_r;
    lfrac_nxt  = lfrac_r;
    pl_dec     = (pl_r != '0) ? pl_r - 1'b1 : pl_r;
    verdict    = 1'b0;
    vdet       = 1'b0;
    vstat      = ST_NO_MATCH;
    vlen       = '0;
    finish     = 1'b0;
    case (phase_r)
      PH_GLOBAL: begin
        if (cnt_r[1:0] == 2'b11) begin
          case (cnt_r[4:2])
            GW_MAGIC: begin
              if (swp == MAGIC_USEC || swp == MAGIC_NSEC) begin
                be_nxt = 1'b0;
                ns_nxt = (swp == MAGIC_NSEC);
              end else if (w == MAGIC_USEC || w == MAGIC_NSEC) begin
                be_nxt = 1'b1;
                ns_nxt = (w == MAGIC_NSEC);
              end else begin
                bad_nxt = 1'b1;
              end
            end
            GW_VERSION: begin
              ver_nxt = be_r ? w : {w[23:16], w[31:24], w[7:0], w[15:8]};
              if (ver_nxt[31:16] == 16'd0) bad_nxt = 1'b1;
            end
            GW_SNAP: begin
              if (hw == 32'd0 || hw > SNAP_MAX) bad_nxt = 1'b1;
              else snap_nxt = hw[24:0];
            end
            GW_LINK: link_nxt = hw;
            default: ;
          endcase
        end
        if (cnt_r[4:0] == GLOBAL_LAST) begin
          if (bad_nxt) begin
            verdict = 1'b1;
          end else begin
            phase_nxt  = PH_RECORD;
            hpos_nxt   = '0;
            rstart_nxt = cnt_nxt;
          end
        end
      end
      PH_RECORD: begin
        if (hpos_r[1:0] == 2'b11) begin
          case (hpos_r[3:2])
            RW_SECONDS:  rw0_nxt = hw;
            RW_FRACTION: rw1_nxt = hw;
            RW_INCL:     rw2_nxt = hw;
            default: ;
          endcase
        end
        if (hpos_r != RECORD_LAST) begin
          hpos_nxt = hpos_r + 1'b1;
        end else begin
          hpos_nxt = '0;
          if (rw2_r > {7'd0, snap_r} || hw < rw2_r) begin
            verdict = 1'b1;
            if (pkts_r != 32'd0) begin
              vstat = ST_MATCHED;
              vdet  = 1'b1;
              vlen  = rstart_r;
            end
          end else if (rw2_r == 32'd0) begin
            finish = 1'b1;
          end else begin
            pl_nxt    = rw2_r[24:0];
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        pl_nxt = pl_dec;
        if (pl_dec == '0) finish = 1'b1;
      end
      default: ;
    endcase
    if (finish) begin
      if (pkts_r == 32'd0) begin
        fsec_nxt  = rw0_r;
        ffrac_nxt = rw1_r;
      end
      lsec_nxt   = rw0_r;
      lfrac_nxt  = rw1_r;
      pkts_nxt   = (pkts_r != '1) ? pkts_r + 1'b1 : pkts_r;
      phase_nxt  = PH_RECORD;
      hpos_nxt   = '0;
      rstart_nxt = cnt_nxt;
    end
  end

  always_comb begin
    res_valid = adv && !done_r && (verdict || step.last_byte);
    if (verdict) begin
      res.status = vstat;
      len_sel    = vlen;
      det        = vdet;
    end else begin
      len_sel = cnt_nxt;
      det     = (phase_nxt != PH_GLOBAL);
      case (phase_nxt)
        PH_GLOBAL:  res.status = ST_PARTIAL_GLOBAL;
        PH_RECORD:  res.status = (hpos_nxt == '0) ? ST_MATCHED : ST_PARTIAL_RECORD;
        PH_PAYLOAD: res.status = ST_PARTIAL_DATA;
        default:    res.status = ST_NO_MATCH;
      endcase
    end
    len_ext = WB'(len_sel);
    res.matched_length = (len_ext > WB'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : len_ext[31:0];
    res.big_endian     = det & be_nxt;
    res.nanosecond     = det & ns_nxt;
    res.version        = det ? ver_nxt : '0;
    res.snap_length    = det ? snap_nxt : '0;
    res.link_type      = det ? link_nxt : '0;
    res.packet_count   = det ? pkts_nxt : '0;
    res.first_seconds  = det ? fsec_nxt : '0;
    res.first_fraction = det ? ffrac_nxt : '0;
    res.final_seconds  = det ? lsec_nxt : '0;
    res.final_fraction = det ? lfrac_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      cnt_r    <= '0;
      phase_r  <= PH_GLOBAL;
      shift_r  <= '0;
      hpos_r   <= '0;
      bad_r    <= 1'b0;
      be_r     <= 1'b0;
      ns_r     <= 1'b0;
      ver_r    <= '0;
      snap_r   <= '0;
      link_r   <= '0;
      rw0_r    <= '0;
      rw1_r    <= '0;
      rw2_r    <= '0;
      pl_r     <= '0;
      rstart_r <= '0;
      pkts_r   <= '0;
      fsec_r   <= '0;
      ffrac_r  <= '0;
      lsec_r   <= '0;
      lfrac_r  <= '0;
      done_r   <= 1'b0;
    end else if (adv && !done_r) begin
      cnt_r    <= cnt_nxt;
      phase_r  <= phase_nxt;
      shift_r  <= w[23:0];
      hpos_r   <= hpos_nxt;
      bad_r    <= bad_nxt;
      be_r     <= be_nxt;
      ns_r     <= ns_nxt;
      ver_r    <= ver_nxt;
      snap_r   <= snap_nxt;
      link_r   <= link_nxt;
      rw0_r    <= rw0_nxt;
      rw1_r    <= rw1_nxt;
      rw2_r    <= rw2_nxt;
      pl_r     <= pl_nxt;
      rstart_r <= rstart_nxt;
      pkts_r   <= pkts_nxt;
      fsec_r   <= fsec_nxt;
      ffrac_r  <= ffrac_nxt;
      lsec_r   <= lsec_nxt;
      lfrac_r  <= lfrac_nxt;
      done_r   <= verdict;
    end
  end

endmodule
`default_nettype wire

/* sv/pcap_stream_validator.sv */
`default_nettype none
// Classic pcap stream checker. Takes one byte per cycle unless the output
// stalls, through an input register and a result register; a verdict is
// registered in the result register from the byte that decides it. Each
// stream yields exactly one result transaction; bytes after the verdict are
// consumed silently until last_byte, which returns the checker to its reset
// state. Throughput is set by the single per-byte header/record tracker update.
module pcap_stream_validator import psv_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire psv_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output psv_out_t      out_data
);

`include "assert_macros.svh"

  logic     s1_valid_r;
  psv_in_t  s1_data_r;
  logic     out_valid_r;
  psv_out_t out_data_r;
  logic     adv;
  logic     res_valid;
  psv_out_t res;

  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_data_r <= res;
    end
  end

  psv_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .step     (s1_data_r),
    .res_valid(res_valid),
    .res      (res)
  );

  `PSV_ASSERT_NEXT(a_stage_hold, s1_valid_r && !adv, s1_valid_r && $stable(s1_data_r), "stalled byte lost")
  `PSV_ASSERT(a_res_on_adv, res_valid, adv, "verdict without a processed byte")
  `PSV_ASSERT(a_ready_cause, !in_ready, s1_valid_r && out_valid_r && !out_ready, "input stalled without backpressure")

endmodule
`default_nettype wire
